[hdl/jvsl_pkg.sv]
// shared types and constants for the joint velocity slew limiter
package jvsl_pkg;

	localparam int LANES = 6;
	localparam int VEL_W = 20;
	localparam int CAP_W = 19;
	localparam int ACC_W = 20;
	localparam int TMO_W = 20;
	localparam int STAMP_W = 32;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W = 20;

	localparam int MIN_INTERVAL_US = 20000;
	localparam int GAP_US_DEF = 100000;
	localparam int JOINTS_DEF = 6;

	localparam logic OP_CMD = 1'b0;
	localparam logic OP_CYCLE = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_SPEED_CAP_1 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SPEED_CAP_6 = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_ACCEL_CAP = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd7;

	localparam logic [CAP_W-1:0] CAP_RESET [LANES] = '{
		19'd34315, 19'd34315, 19'd41177, 19'd52618, 19'd52618, 19'd52618
	};
	localparam logic [ACC_W-1:0] ACCEL_RESET = 20'd82463;
	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 20'd50000;

	typedef enum logic [1:0] {
		K_GAP,
		K_CMD,
		K_CYCLE
	} item_kind_t;

	typedef struct packed {
		logic valid;
		item_kind_t kind;
		logic [STAMP_W-1:0] stamp;
	} stage_t;

endpackage

[hdl/joint_velocity_slew_limiter.sv]
// top level: register file, joint lanes, watchdog and output register
//
// Input stream s_*: one request per accepted beat. s_tuser is the op (0 = velocity
// command, 1 = control cycle), s_tdata carries the time stamp and six joint velocities.
// A command never gives a result; it sets the time base, is dropped when too early,
// reseeds the history after a long gap, or is clamped and slew limited into the held
// command. A control cycle gives exactly one result on m_*: the held command, or zeros
// with m_tuser (stopped) high when the command is invalid or has timed out.
// Configuration writes on cfg_* are always taken (cfg_ready is tied high) and should
// only be made while the block is idle.
// A control cycle passes pipe_s1, pipe_s2 and the output register before m_tvalid.
// Throughput: one request per cycle while s_tready is high, set by the three stage lane
// pipeline whose slew update feeds prev_q straight back into the next command.
// When the receiver stalls, the output register holds its result and requests keep
// flowing until a second result reaches the last stage; then s_tready drops.
// Reset clears the time base, history, command valid flag and the pipeline, and loads
// the register defaults.
module joint_velocity_slew_limiter #(
	parameter int GAP_US = jvsl_pkg::GAP_US_DEF,
	parameter int JOINTS = jvsl_pkg::JOINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// stamp_us, vel_in_1 .. vel_in_6
	input  logic [151:0]                   s_tdata,
	// op
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// vel_out_1 .. vel_out_6
	output logic [119:0]                   m_tdata,
	// stopped
	output logic                           m_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [jvsl_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [jvsl_pkg::CFG_W-1:0]     cfg_data
);
	import jvsl_pkg::*;

	localparam int MD_W = $clog2(GAP_US + 1);

	logic [CAP_W-1:0] cap_q [LANES];
	logic [ACC_W-1:0] accel_q;
	logic [TMO_W-1:0] timeout_q;

	logic advance;
	logic accept;
	stage_t pipe_s1;
	stage_t pipe_s2;
	logic [MD_W-1:0] max_delta_s2;
	logic signed [VEL_W-1:0] held [LANES];

	logic cmd_valid_q;
	logic [STAMP_W-1:0] cmd_time_q;
	logic [STAMP_W-1:0] age;
	logic live;
	logic out_valid_q;
	logic stopped_q;
	logic signed [VEL_W-1:0] out_vel_q [LANES];
	logic emit;

	// register file
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			accel_q <= ACCEL_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index) inside
				[REG_SPEED_CAP_1:REG_SPEED_CAP_6]: cap_q[cfg_index] <= cfg_data[CAP_W-1:0];
				REG_ACCEL_CAP: accel_q <= cfg_data[ACC_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline stalls only when a result cannot leave the last stage
	assign emit = pipe_s2.valid && pipe_s2.kind == K_CYCLE;
	assign advance = !(emit && out_valid_q && !m_tready);
	assign s_tready = advance;
	assign accept = s_tvalid && advance;

	jvsl_front #(
		.GAP_US(GAP_US),
		.MD_W(MD_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.accept(accept),
		.op(s_tuser),
		.stamp(s_tdata[STAMP_W-1:0]),
		.accel_cap(accel_q),
		.pipe_s1(pipe_s1),
		.pipe_s2(pipe_s2),
		.max_delta_s2(max_delta_s2)
	);

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		if (j < JOINTS) begin : g_on
			jvsl_lane #(
				.MD_W(MD_W)
			) u_lane (
				.clk(clk),
				.arst_n(arst_n),
				.advance(advance),
				.pipe_s1(pipe_s1),
				.pipe_s2(pipe_s2),
				.vel_in(s_tdata[STAMP_W + j*VEL_W +: VEL_W]),
				.cap(cap_q[j]),
				.max_delta_s2(max_delta_s2),
				.held(held[j])
			);
		end else begin : g_off
			assign held[j] = '0;
		end
	end

	// watchdog and merge into the output item
	assign age = pipe_s2.stamp - cmd_time_q;
	assign live = cmd_valid_q && (age < {{(STAMP_W-TMO_W){1'b0}}, timeout_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			cmd_time_q <= '0;
		end else if (advance && pipe_s2.valid) begin
			case (pipe_s2.kind)
				K_GAP: cmd_valid_q <= 1'b0;
				K_CMD: begin
					cmd_valid_q <= 1'b1;
					cmd_time_q <= pipe_s2.stamp;
				end
				K_CYCLE: cmd_valid_q <= live;
				default: cmd_valid_q <= cmd_valid_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			stopped_q <= !live;
			for (int k = 0; k < LANES; k++) begin
				out_vel_q[k] <= live ? held[k] : '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = stopped_q;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			m_tdata[k*VEL_W +: VEL_W] = out_vel_q[k];
		end
	end

`ifndef SYNTHESIS
	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("stopped result carries a velocity");
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> m_tvalid)
		else $error("cycle request gave no result");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back pressure");
`endif

endmodule

[hdl/jvsl_front.sv]
// time base tracking, command screening and slew step multiplier
module jvsl_front #(
	parameter int GAP_US = jvsl_pkg::GAP_US_DEF,
	parameter int MD_W = $clog2(GAP_US + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         accept,
	input  logic                         op,
	input  logic [jvsl_pkg::STAMP_W-1:0] stamp,
	input  logic [jvsl_pkg::ACC_W-1:0]   accel_cap,
	output jvsl_pkg::stage_t             pipe_s1,
	output jvsl_pkg::stage_t             pipe_s2,
	output logic [MD_W-1:0]              max_delta_s2
);
	import jvsl_pkg::*;

	logic time_base_q;
	logic [STAMP_W-1:0] last_q;
	logic [STAMP_W-1:0] dt;
	logic pass;
	logic take_stamp;
	item_kind_t kind_n;
	logic [MD_W-1:0] dt_s1;
	logic [ACC_W+MD_W-1:0] prod;

	assign dt = stamp - last_q;

	always_comb begin
		pass = 1'b0;
		take_stamp = 1'b0;
		kind_n = K_CYCLE;
		if (op == OP_CYCLE) begin
			pass = 1'b1;
		end else if (!time_base_q) begin
			take_stamp = 1'b1;
		end else if (dt >= STAMP_W'(MIN_INTERVAL_US)) begin
			take_stamp = 1'b1;
			pass = 1'b1;
			kind_n = (dt > STAMP_W'(GAP_US)) ? K_GAP : K_CMD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_base_q <= 1'b0;
			last_q <= '0;
		end else if (accept && take_stamp) begin
			time_base_q <= 1'b1;
			last_q <= stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s1 <= '{valid: 1'b0, kind: K_CYCLE, stamp: '0};
			pipe_s2 <= '{valid: 1'b0, kind: K_CYCLE, stamp: '0};
		end else if (advance) begin
			pipe_s1 <= '{valid: accept && pass, kind: kind_n, stamp: stamp};
			pipe_s2 <= pipe_s1;
		end
	end

	assign prod = {{MD_W{1'b0}}, accel_cap} * {{ACC_W{1'b0}}, dt_s1};

	always_ff @(posedge clk) begin
		if (advance) begin
			dt_s1 <= dt[MD_W-1:0];
			max_delta_s2 <= prod[ACC_W+MD_W-1:ACC_W];
		end
	end

`ifndef SYNTHESIS
	a_first_cmd_no_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_CMD && !time_base_q) |=> !pipe_s1.valid)
		else $error("first command entered the pipeline");
	a_cycle_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_CYCLE) |=> (pipe_s1.valid && pipe_s1.kind == K_CYCLE))
		else $error("cycle request lost");
	a_stamp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && op == OP_CMD) |=> $stable(last_q))
		else $error("time base moved without a command");
`endif

endmodule

[hdl/jvsl_lane.sv]
// one joint lane: speed clamp, slew limit and held command
module jvsl_lane #(
	parameter int MD_W = $clog2(jvsl_pkg::GAP_US_DEF + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  jvsl_pkg::stage_t                  pipe_s1,
	input  jvsl_pkg::stage_t                  pipe_s2,
	input  logic signed [jvsl_pkg::VEL_W-1:0] vel_in,
	input  logic [jvsl_pkg::CAP_W-1:0]        cap,
	input  logic [MD_W-1:0]                   max_delta_s2,
	output logic signed [jvsl_pkg::VEL_W-1:0] held
);
	import jvsl_pkg::*;

	localparam int WX = VEL_W + 2;

	logic signed [VEL_W-1:0] vin_s1;
	logic signed [VEL_W-1:0] q_s2;
	logic signed [VEL_W-1:0] q_n;
	logic signed [VEL_W:0] vin_x;
	logic signed [VEL_W:0] cap_x;
	logic signed [VEL_W:0] ncap_x;
	logic signed [VEL_W-1:0] prev_q;
	logic signed [VEL_W-1:0] held_q;
	logic signed [WX-1:0] prev_x;
	logic signed [WX-1:0] delta;
	logic signed [WX-1:0] delta_cl;
	logic signed [WX-1:0] md_x;
	logic signed [WX-1:0] md_neg;
	logic signed [WX-1:0] sum;

	// speed clamp, raw value kept for a gap reseed
	always_comb begin
		vin_x = {vin_s1[VEL_W-1], vin_s1};
		cap_x = $signed({2'b00, cap});
		ncap_x = -cap_x;
		if (pipe_s1.kind == K_GAP) begin
			q_n = vin_s1;
		end else if (vin_x > cap_x) begin
			q_n = cap_x[VEL_W-1:0];
		end else if (vin_x < ncap_x) begin
			q_n = ncap_x[VEL_W-1:0];
		end else begin
			q_n = vin_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vin_s1 <= vel_in;
			q_s2 <= q_n;
		end
	end

	// slew limit against the previous velocity
	always_comb begin
		prev_x = {{2{prev_q[VEL_W-1]}}, prev_q};
		md_x = $signed({{(WX-MD_W){1'b0}}, max_delta_s2});
		md_neg = -md_x;
		delta = {{2{q_s2[VEL_W-1]}}, q_s2} - prev_x;
		if (delta > md_x) begin
			delta_cl = md_x;
		end else if (delta < md_neg) begin
			delta_cl = md_neg;
		end else begin
			delta_cl = delta;
		end
		sum = prev_x + delta_cl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (advance && pipe_s2.valid) begin
			case (pipe_s2.kind)
				K_GAP: prev_q <= q_s2;
				K_CMD: prev_q <= sum[VEL_W-1:0];
				default: prev_q <= prev_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pipe_s2.valid && pipe_s2.kind == K_CMD) begin
			held_q <= sum[VEL_W-1:0];
		end
	end

	assign held = held_q;

endmodule
